/* design/assert_macros.svh */
// ============================================================================
// Assertion macros
// Shared concurrent assertion helpers for the tokenizer design files.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/svt_pkg.sv */
// ============================================================================
// Tokenizer package
// Types and constants shared by the front parser and the token queue.
// ============================================================================
package svt_pkg;

    typedef enum logic [3:0] {
        PH_TYPE, PH_CNT_HEAD, PH_CNT_14, PH_CNT_32, PH_STR_HEAD, PH_STR_14,
        PH_STR_32, PH_STR_TEXT, PH_SCORE_HEAD, PH_SCORE_TEXT, PH_TRAILER
    } t_phase;

    typedef enum logic [2:0] {
        VT_UNKNOWN, VT_STRING, VT_LIST, VT_SET, VT_ZSET, VT_HASH
    } t_vtype;

    localparam logic [3:0] TK_TYPE       = 4'd0;
    localparam logic [3:0] TK_COUNT      = 4'd1;
    localparam logic [3:0] TK_STR_LEN    = 4'd2;
    localparam logic [3:0] TK_STR_BYTE   = 4'd3;
    localparam logic [3:0] TK_SPECIAL    = 4'd4;
    localparam logic [3:0] TK_SCORE_LEN  = 4'd5;
    localparam logic [3:0] TK_SCORE_BYTE = 4'd6;
    localparam logic [3:0] TK_VERSION    = 4'd7;
    localparam logic [3:0] TK_DONE       = 4'd8;
    localparam logic [3:0] TK_ERROR      = 4'd9;

    localparam logic [63:0] ERR_SHORT   = 64'd0;
    localparam logic [63:0] ERR_LENGTH  = 64'd1;
    localparam logic [63:0] ERR_SCORE   = 64'd2;
    localparam logic [63:0] ERR_TRAILER = 64'd3;
    localparam logic [63:0] ERR_VERSION = 64'd4;

    localparam logic [2:0] CFG_MAX_VERSION = 3'd0;
    localparam logic [2:0] CFG_CODE_STRING = 3'd1;
    localparam logic [2:0] CFG_CODE_LIST   = 3'd2;
    localparam logic [2:0] CFG_CODE_SET    = 3'd3;
    localparam logic [2:0] CFG_CODE_ZSET   = 3'd4;
    localparam logic [2:0] CFG_CODE_HASH   = 3'd5;

    localparam logic [1:0] PFX_6  = 2'b00;
    localparam logic [1:0] PFX_14 = 2'b01;
    localparam logic [1:0] PFX_32 = 2'b10;

    localparam logic [7:0] SCORE_NAN  = 8'd253;
    localparam logic [7:0] SCORE_PINF = 8'd254;
    localparam logic [7:0] SCORE_NINF = 8'd255;

    localparam logic [3:0] TRAILER_LAST = 4'd9;

    // One token as it travels from the parser to the queue.
    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic        last;
    } t_token;

    // Type codes and the maximum version held in the configuration registers.
    typedef struct packed {
        logic [15:0] max_version;
        logic [7:0]  code_string;
        logic [7:0]  code_list;
        logic [7:0]  code_set;
        logic [7:0]  code_zset;
        logic [7:0]  code_hash;
    } t_cfg;

endpackage

/* design/svt_front.sv */
// ============================================================================
// Tokenizer front parser
// Classifies each blob byte, advances the parse state and forms a token where one is due.
// ============================================================================
`include "assert_macros.svh"

module svt_front import svt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_blob_end,
    input  t_cfg        i_cfg,
    output logic        o_tok_valid,
    output t_token      o_tok
);

    t_phase      r_phase, n_phase;
    t_vtype      r_vtype, n_vtype;
    logic [31:0] r_elems, n_elems;
    logic        r_part, n_part;
    logic [31:0] r_text, n_text;
    logic [31:0] r_acc, n_acc;
    logic [3:0]  r_pos, n_pos;
    logic [15:0] r_ver, n_ver;
    logic [63:0] r_csum, n_csum;
    logic        r_err, n_err;

    logic        has_tok, has_err, complete, is_count;
    logic [63:0] err_code;
    logic [31:0] len_v, text_dec;
    logic        len_fire;
    logic [15:0] ver_full;

    // Parse state registers; a blob end clears everything.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_vtype <= VT_UNKNOWN;
            r_elems <= '0;
            r_part  <= 1'b0;
            r_text  <= '0;
            r_acc   <= '0;
            r_pos   <= '0;
            r_ver   <= '0;
            r_csum  <= '0;
            r_err   <= 1'b0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_vtype <= n_vtype;
            r_elems <= n_elems;
            r_part  <= n_part;
            r_text  <= n_text;
            r_acc   <= n_acc;
            r_pos   <= n_pos;
            r_ver   <= n_ver;
            r_csum  <= n_csum;
            r_err   <= n_err;
        end
    end

    // Next state and token for one byte.
    always_comb begin
        n_phase  = r_phase;
        n_vtype  = r_vtype;
        n_elems  = r_elems;
        n_part   = r_part;
        n_text   = r_text;
        n_acc    = r_acc;
        n_pos    = r_pos;
        n_ver    = r_ver;
        n_csum   = r_csum;
        n_err    = r_err;
        has_tok  = 1'b0;
        has_err  = 1'b0;
        complete = 1'b0;
        err_code = ERR_SHORT;
        o_tok    = '0;
        len_v    = '0;
        len_fire = 1'b0;
        text_dec = r_text - 32'd1;
        ver_full = {i_data_byte, r_ver[7:0]};
        is_count = (r_phase == PH_CNT_HEAD) || (r_phase == PH_CNT_14)
                   || (r_phase == PH_CNT_32);

        case (r_phase)
            PH_CNT_HEAD, PH_STR_HEAD: begin
                case (i_data_byte[7:6])
                    PFX_6: begin
                        len_v    = {26'd0, i_data_byte[5:0]};
                        len_fire = 1'b1;
                    end
                    PFX_14: begin
                        n_acc   = {18'd0, i_data_byte[5:0], 8'd0};
                        n_phase = is_count ? PH_CNT_14 : PH_STR_14;
                    end
                    PFX_32: begin
                        n_acc   = '0;
                        n_pos   = '0;
                        n_phase = is_count ? PH_CNT_32 : PH_STR_32;
                    end
                    default: begin
                        has_err  = 1'b1;
                        err_code = ERR_LENGTH;
                    end
                endcase
            end
            PH_CNT_14, PH_STR_14: begin
                len_v    = r_acc | {24'd0, i_data_byte};
                len_fire = 1'b1;
            end
            PH_CNT_32, PH_STR_32: begin
                case (r_pos[1:0])
                    2'd0:    n_acc = r_acc | {24'd0, i_data_byte};
                    2'd1:    n_acc = r_acc | {16'd0, i_data_byte, 8'd0};
                    2'd2:    n_acc = r_acc | {8'd0, i_data_byte, 16'd0};
                    default: n_acc = r_acc | {i_data_byte, 24'd0};
                endcase
                if (r_pos[1:0] == 2'd3) begin
                    n_pos    = '0;
                    len_v    = n_acc;
                    len_fire = 1'b1;
                end else begin
                    n_pos = {2'b00, r_pos[1:0] + 2'd1};
                end
            end
            PH_STR_TEXT, PH_SCORE_TEXT: begin
                n_text      = text_dec;
                has_tok     = 1'b1;
                o_tok.kind  = (r_phase == PH_SCORE_TEXT) ? TK_SCORE_BYTE : TK_STR_BYTE;
                o_tok.value = {56'd0, i_data_byte};
                o_tok.last  = (text_dec == 32'd0);
                if (text_dec == 32'd0) begin
                    if (r_phase == PH_SCORE_TEXT || r_vtype == VT_LIST
                        || r_vtype == VT_SET || r_part) begin
                        // Element finished.
                        n_part  = 1'b0;
                        n_elems = r_elems - 32'd1;
                        n_phase = (r_elems == 32'd1) ? PH_TRAILER : PH_STR_HEAD;
                    end else if (r_vtype == VT_STRING) begin
                        n_phase = PH_TRAILER;
                    end else begin
                        n_part  = 1'b1;
                        n_phase = (r_vtype == VT_ZSET) ? PH_SCORE_HEAD : PH_STR_HEAD;
                    end
                    if (n_phase == PH_TRAILER) begin
                        n_pos  = '0;
                        n_ver  = '0;
                        n_csum = '0;
                    end
                end
            end
            PH_SCORE_HEAD: begin
                if (i_data_byte == 8'd0) begin
                    has_err  = 1'b1;
                    err_code = ERR_SCORE;
                end else if (i_data_byte >= SCORE_NAN) begin
                    has_tok    = 1'b1;
                    o_tok.kind = TK_SPECIAL;
                    o_tok.value = (i_data_byte == SCORE_NAN)  ? 64'd0 :
                                  (i_data_byte == SCORE_PINF) ? 64'd1 : 64'd2;
                    n_part  = 1'b0;
                    n_elems = r_elems - 32'd1;
                    if (r_elems == 32'd1) begin
                        n_phase = PH_TRAILER;
                        n_pos   = '0;
                        n_ver   = '0;
                        n_csum  = '0;
                    end else begin
                        n_phase = PH_STR_HEAD;
                    end
                end else begin
                    has_tok     = 1'b1;
                    o_tok.kind  = TK_SCORE_LEN;
                    o_tok.value = {56'd0, i_data_byte};
                    n_text      = {24'd0, i_data_byte};
                    n_phase     = PH_SCORE_TEXT;
                end
            end
            PH_TRAILER: begin
                if (r_pos == 4'd0) begin
                    n_ver = {8'd0, i_data_byte};
                end else if (r_pos == 4'd1) begin
                    n_ver       = ver_full;
                    has_tok     = 1'b1;
                    o_tok.kind  = TK_VERSION;
                    o_tok.value = {48'd0, ver_full};
                end else if (r_pos <= TRAILER_LAST) begin
                    n_csum = r_csum | ({56'd0, i_data_byte} << {r_pos[2:0] - 3'd2, 3'd0});
                end
                if (r_pos >= TRAILER_LAST) begin
                    if (!i_blob_end) begin
                        has_err  = 1'b1;
                        err_code = ERR_TRAILER;
                    end else if (r_ver > i_cfg.max_version) begin
                        has_err  = 1'b1;
                        err_code = ERR_VERSION;
                    end else begin
                        has_tok     = 1'b1;
                        complete    = 1'b1;
                        o_tok.kind  = TK_DONE;
                        o_tok.value = n_csum;
                    end
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end
            default: begin
                has_tok     = 1'b1;
                o_tok.kind  = TK_TYPE;
                o_tok.value = {56'd0, i_data_byte};
                if (i_data_byte == i_cfg.code_string)    n_vtype = VT_STRING;
                else if (i_data_byte == i_cfg.code_list) n_vtype = VT_LIST;
                else if (i_data_byte == i_cfg.code_set)  n_vtype = VT_SET;
                else if (i_data_byte == i_cfg.code_zset) n_vtype = VT_ZSET;
                else if (i_data_byte == i_cfg.code_hash) n_vtype = VT_HASH;
                else                                     n_vtype = VT_UNKNOWN;
                if (n_vtype == VT_UNKNOWN) begin
                    n_phase = PH_TRAILER;
                    n_pos   = '0;
                    n_ver   = '0;
                    n_csum  = '0;
                end else if (n_vtype == VT_STRING) begin
                    n_phase = PH_STR_HEAD;
                end else begin
                    n_phase = PH_CNT_HEAD;
                end
            end
        endcase

        // A completed length or count.
        if (len_fire) begin
            has_tok     = 1'b1;
            o_tok.value = {32'd0, len_v};
            if (is_count) begin
                o_tok.kind = TK_COUNT;
                n_elems    = len_v;
                n_part     = 1'b0;
                n_phase    = (len_v == 32'd0) ? PH_TRAILER : PH_STR_HEAD;
            end else begin
                o_tok.kind = TK_STR_LEN;
                if (len_v != 32'd0) begin
                    n_text  = len_v;
                    n_phase = PH_STR_TEXT;
                end else if (r_vtype == VT_STRING) begin
                    n_phase = PH_TRAILER;
                end else if (!r_part && (r_vtype == VT_HASH || r_vtype == VT_ZSET)) begin
                    n_part  = 1'b1;
                    n_phase = (r_vtype == VT_ZSET) ? PH_SCORE_HEAD : PH_STR_HEAD;
                end else begin
                    n_part  = 1'b0;
                    n_elems = r_elems - 32'd1;
                    n_phase = (r_elems == 32'd1) ? PH_TRAILER : PH_STR_HEAD;
                end
            end
            if (n_phase == PH_TRAILER) begin
                n_pos  = '0;
                n_ver  = '0;
                n_csum = '0;
            end
        end

        // End of blob before completion.
        if (!has_err && i_blob_end && !complete) begin
            has_err  = 1'b1;
            err_code = (n_phase == PH_TRAILER) ? ERR_TRAILER : ERR_SHORT;
        end
        if (has_err) begin
            has_tok     = 1'b1;
            o_tok.kind  = TK_ERROR;
            o_tok.value = err_code;
            o_tok.last  = 1'b0;
            n_err       = 1'b1;
        end

        // Bytes after an error are dropped.
        if (r_err) begin
            has_tok = 1'b0;
            n_phase = r_phase;
            n_vtype = r_vtype;
            n_elems = r_elems;
            n_part  = r_part;
            n_text  = r_text;
            n_acc   = r_acc;
            n_pos   = r_pos;
            n_ver   = r_ver;
            n_csum  = r_csum;
            n_err   = 1'b1;
        end
        if (i_blob_end) begin
            n_phase = PH_TYPE;
            n_vtype = VT_UNKNOWN;
            n_elems = '0;
            n_part  = 1'b0;
            n_text  = '0;
            n_acc   = '0;
            n_pos   = '0;
            n_ver   = '0;
            n_csum  = '0;
            n_err   = 1'b0;
        end
    end

    assign o_tok_valid = i_valid && has_tok;

    `ASSERT_IMPL(a_no_tok_after_err, i_clk, i_rst_n, r_err, !o_tok_valid)
    `ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_valid && i_blob_end,
                 r_phase == PH_TYPE && !r_err)
    `ASSERT_IMPL(a_pos_range, i_clk, i_rst_n, r_phase == PH_TRAILER, r_pos <= TRAILER_LAST)

endmodule

/* design/svt_queue.sv */
// ============================================================================
// Token queue
// Small queue between the parser and the result port.
// ============================================================================
`include "assert_macros.svh"

module svt_queue import svt_pkg::*; #(
    parameter int DEPTH_LOG2 = 2
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_tok,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_token o_tok
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    t_token                r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wr, r_rd;
    logic [DEPTH_LOG2:0]   r_cnt;
    logic                  do_pop;

    assign o_full  = (r_cnt == DEPTH_LOG2'(0) + (DEPTH_LOG2 + 1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_pop  = i_pop && !o_empty;
    assign o_tok   = r_mem[r_rd];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (DEPTH_LOG2 + 1)'(i_push) - (DEPTH_LOG2 + 1)'(do_pop);
        end
    end

    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, o_full, !i_push)
    `ASSERT_NEXT(a_count_pop, i_clk, i_rst_n, do_pop && !i_push, r_cnt == $past(r_cnt) - 1'b1)

endmodule

/* design/serialized_value_tokenizer_top.sv */
// ============================================================================
// Serialized value tokenizer
// Parses a serialized key-value blob into tokens, one byte per cycle while the token queue is not full.
// ============================================================================
//  Channel   | Ports                                       | Handshake
//  input     | i_data_byte, i_blob_end                     | push / full
//  result    | o_token_kind, o_token_value, o_last_of_text | empty / pop
//  config    | i_cfg_we, i_cfg_index, i_cfg_data           | write only
//
// One byte is accepted in every cycle in which the token queue is not full.
// The parser settles a byte within its cycle, so the token is written into
// the queue at the accepting edge and can be popped from the next cycle.
// The input stalls only while the queue is full, even in a cycle in which a
// token is popped.
// Reset is synchronous; it returns the configuration to its defaults and clears the parser and queue at once.
`include "assert_macros.svh"

module serialized_value_tokenizer_top import svt_pkg::*; #(
    parameter int QUEUE_DEPTH_LOG2 = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_blob_end,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_token_kind,
    output logic [63:0] o_token_value,
    output logic        o_last_of_text,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg   r_cfg;
    logic   accept, tok_valid;
    t_token tok, q_tok;

    assign accept = push && !full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_version <= 16'd6;
            r_cfg.code_string <= 8'd0;
            r_cfg.code_list   <= 8'd1;
            r_cfg.code_set    <= 8'd2;
            r_cfg.code_zset   <= 8'd3;
            r_cfg.code_hash   <= 8'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_VERSION: r_cfg.max_version <= i_cfg_data;
                CFG_CODE_STRING: r_cfg.code_string <= i_cfg_data[7:0];
                CFG_CODE_LIST:   r_cfg.code_list   <= i_cfg_data[7:0];
                CFG_CODE_SET:    r_cfg.code_set    <= i_cfg_data[7:0];
                CFG_CODE_ZSET:   r_cfg.code_zset   <= i_cfg_data[7:0];
                CFG_CODE_HASH:   r_cfg.code_hash   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Front parser.
    svt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_data_byte (i_data_byte),
        .i_blob_end  (i_blob_end),
        .i_cfg       (r_cfg),
        .o_tok_valid (tok_valid),
        .o_tok       (tok)
    );

    // Token queue towards the result port.
    svt_queue #(.DEPTH_LOG2(QUEUE_DEPTH_LOG2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_valid),
        .i_tok   (tok),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_tok   (q_tok)
    );

    assign o_token_kind   = q_tok.kind;
    assign o_token_value  = q_tok.value;
    assign o_last_of_text = q_tok.last;

    `ASSERT_IMPL(a_kind_range, i_clk, i_rst_n, !empty, o_token_kind <= TK_ERROR)
    `ASSERT_IMPL(a_last_text, i_clk, i_rst_n, !empty && o_last_of_text,
                 o_token_kind == TK_STR_BYTE || o_token_kind == TK_SCORE_BYTE)

endmodule
